### sv/ip_address_classifier_defines.svh
// Assertion macros for the address classifier checkers.
`ifndef IP_ADDRESS_CLASSIFIER_DEFINES_SVH
`define IP_ADDRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define IPAC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipac: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define IPAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipac: next-cycle check failed");

`endif

### sv/ipac_pkg.sv
package ipac_pkg;

  localparam int unsigned TYPE_W = 5;
  localparam int unsigned SCORE_W = 8;

  typedef logic [TYPE_W-1:0] type_code_t;
  typedef logic [SCORE_W-1:0] score_t;

  // Scope type codes
  localparam type_code_t TC_ZERO         = 5'd0;
  localparam type_code_t TC_INVALID      = 5'd1;
  localparam type_code_t TC_V4_PUBLIC    = 5'd2;
  localparam type_code_t TC_V4_SITE      = 5'd3;
  localparam type_code_t TC_V4_LINK      = 5'd4;
  localparam type_code_t TC_V4_LOCAL     = 5'd5;
  localparam type_code_t TC_V4_BCAST     = 5'd6;
  localparam type_code_t TC_V4_MC_LINK   = 5'd7;
  localparam type_code_t TC_V4_MC_SITE   = 5'd8;
  localparam type_code_t TC_V4_MC_PUBLIC = 5'd9;
  localparam type_code_t TC_V6_LOCAL     = 5'd10;
  localparam type_code_t TC_V6_PUBLIC    = 5'd11;
  localparam type_code_t TC_V6_SITE      = 5'd12;
  localparam type_code_t TC_V6_LINK      = 5'd13;
  localparam type_code_t TC_V6_MC_LINK   = 5'd14;
  localparam type_code_t TC_V6_MC_SITE   = 5'd15;
  localparam type_code_t TC_V6_MC_PUBLIC = 5'd16;

  localparam score_t SCORE_NONE = 8'd255;

  // Upper word of the low half for an IPv4-mapped address
  localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_FFFF;

  // Highest IPv4 address still counted as link-scope multicast
  localparam logic [31:0] V4_MC_LINK_TOP = 32'hE000_00FF;

  // Register indexes on the config port
  localparam logic [1:0] REG_REF_ADDR_HIGH = 2'd0;
  localparam logic [1:0] REG_REF_ADDR_LOW  = 2'd1;
  localparam logic [1:0] REG_MASK_HIGH     = 2'd2;
  localparam logic [1:0] REG_MASK_LOW      = 2'd3;

  function automatic score_t score_of_type(input type_code_t tc);
    score_t s;
    case (tc)
      TC_V6_LOCAL:  s = 8'd0;
      TC_V4_LOCAL:  s = 8'd1;
      TC_V4_PUBLIC: s = 8'd2;
      TC_V4_SITE:   s = 8'd3;
      TC_V6_PUBLIC: s = 8'd4;
      TC_V6_SITE:   s = 8'd5;
      TC_V6_LINK:   s = 8'd6;
      TC_V4_LINK:   s = 8'd7;
      default:      s = SCORE_NONE;
    endcase
    return s;
  endfunction

endpackage

### sv/ip_address_classifier.sv
// IPv4/IPv6 address scope classifier. Each request carries one 128-bit
// address as addr_high/addr_low (IPv4 in the mapped form ::ffff:a.b.c.d) and
// yields one result: scope type_code, preference score (0..7, 255 when
// unranked), is_public, is_routable, and same_subnet against the reference
// address and mask held in the config registers. The block takes one request
// per clock while in_stall is low. The request lands in the input register
// when accepted, and compare logic then fills the result register from it and
// sets out_valid, unless a stalled result holds that register. in_stall follows
// out_stall only when both stages are full, so a waiting result does not
// stop the next request from entering. Config registers (64-bit, APB at
// 8*index: ref_addr_high, ref_addr_low, mask_high, mask_low) must be written
// while no request is in flight. A zero mask_high selects IPv4 mask mode.
module ip_address_classifier (
  input  logic                    clk,
  input  logic                    rst,
  // config port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [63:0]             addr_high,
  input  logic [63:0]             addr_low,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output ipac_pkg::type_code_t    type_code,
  output ipac_pkg::score_t        score,
  output logic                    is_public,
  output logic                    is_routable,
  output logic                    same_subnet
);
  import ipac_pkg::*;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [63:0] ref_addr_high;
  logic [63:0] ref_addr_low;
  logic [63:0] mask_high;
  logic [63:0] mask_low;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];   // byte address 8*index, low bits ignored
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_addr_high <= '0;
      ref_addr_low  <= '0;
      mask_high     <= '0;
      mask_low      <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_REF_ADDR_HIGH: ref_addr_high <= pwdata;
        REG_REF_ADDR_LOW:  ref_addr_low  <= pwdata;
        REG_MASK_HIGH:     mask_high     <= pwdata;
        REG_MASK_LOW:      mask_low      <= pwdata;
        default:           ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REF_ADDR_HIGH: prdata = ref_addr_high;
      REG_REF_ADDR_LOW:  prdata = ref_addr_low;
      REG_MASK_HIGH:     prdata = mask_high;
      REG_MASK_LOW:      prdata = mask_low;
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control: input stage, result stage
  // ---------------------------------------------------------------------
  logic        in_reg_valid;
  logic [63:0] hi;
  logic [63:0] lo;
  logic        res_load;
  logic        in_load;

  assign res_load = !out_valid || !out_stall;
  assign in_stall = in_reg_valid && !res_load;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_load) begin
      in_reg_valid <= 1'b1;
    end else if (res_load) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      hi <= addr_high;
      lo <= addr_low;
    end
  end

  // ---------------------------------------------------------------------
  // Classification from the input register
  // ---------------------------------------------------------------------
  logic        hi_zero;
  logic        mapped;
  logic [31:0] v4;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [15:0] v4_top;   // upper 16 bits of the IPv4 address
  logic [15:0] w0;       // first IPv6 group
  type_code_t  v4_tc;
  type_code_t  v6_tc;
  type_code_t  tc_next;
  logic        public_next;
  logic        routable_next;
  logic        subnet_next;
  logic        v6_global;
  logic        v6_ula;
  logic        ref_mapped;
  logic        mask_mapped;

  assign hi_zero = (hi == '0);
  assign mapped  = hi_zero && (lo[63:32] == V4_MAPPED_TAG);
  assign v4      = lo[31:0];
  assign b0      = v4[31:24];
  assign b1      = v4[23:16];
  assign v4_top  = v4[31:16];
  assign w0      = hi[63:48];

  assign v6_global = ((w0 & 16'hE000) == 16'h2000);
  assign v6_ula    = ((w0 & 16'hFE00) == 16'hFC00);

  // IPv4 scope
  always_comb begin
    if (b0 >= 8'd224) begin
      if (v4 == 32'hFFFF_FFFF)   v4_tc = TC_V4_BCAST;
      else if (b0 < 8'd239)      v4_tc = (v4 <= V4_MC_LINK_TOP) ? TC_V4_MC_LINK
                                                                : TC_V4_MC_PUBLIC;
      else if (b0 == 8'd239)     v4_tc = TC_V4_MC_SITE;
      else                       v4_tc = TC_INVALID;
    end else if (b0 == 8'd0) begin
      v4_tc = TC_INVALID;
    end else if (b0 == 8'd10) begin
      v4_tc = TC_V4_SITE;
    end else if (b0 == 8'd127) begin
      v4_tc = TC_V4_LOCAL;
    end else if (b0 == 8'd169) begin
      v4_tc = (b1 == 8'd254) ? TC_V4_LINK : TC_V4_PUBLIC;
    end else if (b0 == 8'd172) begin
      v4_tc = (b1[7:4] == 4'h1) ? TC_V4_SITE : TC_V4_PUBLIC;
    end else if (b0 == 8'd192) begin
      v4_tc = (b1 == 8'd168) ? TC_V4_SITE : TC_V4_PUBLIC;
    end else begin
      v4_tc = TC_V4_PUBLIC;
    end
  end

  // IPv6 scope, high half nonzero
  always_comb begin
    if (v6_global) begin
      v6_tc = TC_V6_PUBLIC;
    end else if (v6_ula) begin
      v6_tc = TC_V6_SITE;
    end else if ((w0 & 16'hFFC0) == 16'hFE80) begin
      v6_tc = TC_V6_LINK;
    end else if (w0[15:8] == 8'hFF) begin
      case (w0[3:0])
        4'h2:                   v6_tc = TC_V6_MC_LINK;
        4'h3, 4'h4, 4'h5, 4'h8: v6_tc = TC_V6_MC_SITE;
        4'hE:                   v6_tc = TC_V6_MC_PUBLIC;
        default:                v6_tc = TC_INVALID;
      endcase
    end else begin
      v6_tc = TC_INVALID;
    end
  end

  always_comb begin
    if (!hi_zero)              tc_next = v6_tc;
    else if (lo == 64'd0)      tc_next = TC_ZERO;
    else if (lo == 64'd1)      tc_next = TC_V6_LOCAL;
    else if (mapped)           tc_next = v4_tc;
    else                       tc_next = TC_INVALID;
  end

  // Public: 0/8, private, loopback, link and class D/E ranges excluded; IPv6 global only
  always_comb begin
    if (!hi_zero) begin
      public_next = v6_global;
    end else if (!mapped) begin
      public_next = 1'b0;
    end else if (b0 == 8'd0 || b0 == 8'd10 || b0 == 8'd127) begin
      public_next = 1'b0;
    end else if (b0 == 8'd169) begin
      public_next = (b1 != 8'd254);
    end else if (b0 == 8'd172) begin
      public_next = (b1[7:4] != 4'h1);
    end else if (b0 == 8'd192) begin
      public_next = (b1 != 8'd168);
    end else begin
      public_next = (b0 < 8'd224);
    end
  end

  // Routable: three IPv4 windows on the top 16 bits; IPv6 global or ULA
  always_comb begin
    if (!hi_zero) begin
      routable_next = v6_global || v6_ula;
    end else if (!mapped) begin
      routable_next = 1'b0;
    end else begin
      routable_next = (v4_top >= 16'h0100 && v4_top < 16'h7F00) ||
                      (v4_top >= 16'h8000 && v4_top < 16'hA9FE) ||
                      (v4_top >= 16'hA9FF && v4_top < 16'hE000);
    end
  end

  // Subnet match
  assign ref_mapped  = (ref_addr_high == '0) && (ref_addr_low[63:32] == V4_MAPPED_TAG);
  assign mask_mapped = (mask_low[63:32] == V4_MAPPED_TAG);

  always_comb begin
    if (mask_high == '0) begin
      // IPv4 mask mode; an all-zero IPv4 mask never matches
      subnet_next = mask_mapped && mapped && ref_mapped &&
                    (mask_low[31:0] != '0) &&
                    (((lo[31:0] ^ ref_addr_low[31:0]) & mask_low[31:0]) == '0);
    end else begin
      subnet_next = !mapped && !ref_mapped &&
                    (((hi ^ ref_addr_high) & mask_high) == '0) &&
                    (((lo ^ ref_addr_low) & mask_low) == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && in_reg_valid) begin
      type_code   <= tc_next;
      score       <= score_of_type(tc_next);
      is_public   <= public_next;
      is_routable <= routable_next;
      same_subnet <= subnet_next;
    end
  end

endmodule

### sv/ipac_checker.sv
`include "ip_address_classifier_defines.svh"

module ipac_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input ipac_pkg::type_code_t type_code,
  input ipac_pkg::score_t     score,
  input logic                 is_public,
  input logic                 is_routable
);
  import ipac_pkg::*;

  // score always agrees with the reported type
  `IPAC_ASSERT_NOW(a_score_matches_type, out_valid, score == score_of_type(type_code))

  // type code stays within the defined codes
  `IPAC_ASSERT_NOW(a_type_in_range, out_valid, type_code <= TC_V6_MC_PUBLIC)

  // a public address has a public scope and is routable
  `IPAC_ASSERT_NOW(a_public_is_routable, out_valid && is_public,
    is_routable && (type_code == TC_V4_PUBLIC || type_code == TC_V6_PUBLIC))

  // a stalled result holds
  `IPAC_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall,
    out_valid && $stable(type_code) && $stable(score) && $stable(is_public))

endmodule

bind ip_address_classifier ipac_checker u_ipac_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .type_code   (type_code),
  .score       (score),
  .is_public   (is_public),
  .is_routable (is_routable)
);

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ipac_pkg::*;

  // Run bounds. Worst case per request is roughly a send gap, a result stall
  // and the pipeline depth; the limit is many times that.
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 55;
  // Result count at which the receiver holds off for a long stretch; lands in
  // a back-to-back phase so the sender keeps offering through the hold.
  localparam int unsigned HOLD_AT         = 100;
  localparam int unsigned HOLD_CYCLES     = 80;
  // Pipeline is two deep; the drain lets it settle before config writes and the end.
  localparam int unsigned SETTLE_CYCLES   = 4;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } request_t;

  typedef struct packed {
    type_code_t tc;
    score_t     sc;
    logic       pub;
    logic       rt;
    logic       sn;
  } scope_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [63:0] pwdata   = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] addr_high = '0;
  logic [63:0] addr_low  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  type_code_t  type_code;
  score_t      score;
  logic        is_public;
  logic        is_routable;
  logic        same_subnet;

  // Local copy of the subnet registers, updated as each write lands.
  logic [63:0] ref_hi  = '0;
  logic [63:0] ref_lo  = '0;
  logic [63:0] mask_hi = '0;
  logic [63:0] mask_lo = '0;

  request_t    pending_q[$];        // requests not yet offered
  scope_t      predicted_scope_q[$]; // one entry per accepted request
  request_t    next_req;
  scope_t      want;
  int unsigned errors     = 0;
  int unsigned checked    = 0;
  int unsigned cycles     = 0;
  int unsigned send_wait  = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          paced      = 1'b1;   // clear: both sides run back to back

  ip_address_classifier uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .addr_high   (addr_high),
    .addr_low    (addr_low),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .type_code   (type_code),
    .score       (score),
    .is_public   (is_public),
    .is_routable (is_routable),
    .same_subnet (same_subnet)
  );

  always #1 clk = ~clk;

  // Expected result for one address under the current register copy.
  function automatic scope_t classify_address(input logic [63:0] hi, input logic [63:0] lo);
    scope_t      v;
    logic [7:0]  o0;
    logic [7:0]  o1;
    logic [15:0] w0;
    logic [15:0] top16;
    logic        mapped;
    logic        ref_mapped;
    o0         = lo[31:24];
    o1         = lo[23:16];
    top16      = lo[31:16];
    w0         = hi[63:48];
    mapped     = (hi == '0) && (lo[63:32] == V4_MAPPED_TAG);
    ref_mapped = (ref_hi == '0) && (ref_lo[63:32] == V4_MAPPED_TAG);

    // scope: IPv6 prefixes when the high half is set, else zero/loopback/IPv4
    if (hi != '0) begin
      if (w0[15:13] == 3'b001) v.tc = TC_V6_PUBLIC;
      else if (w0[15:9] == 7'b1111_110) v.tc = TC_V6_SITE;
      else if (w0[15:6] == 10'b1111_1110_10) v.tc = TC_V6_LINK;
      else if (w0[15:8] == 8'hFF) begin
        case (w0[3:0])
          4'h2: v.tc = TC_V6_MC_LINK;
          4'h3, 4'h4, 4'h5, 4'h8: v.tc = TC_V6_MC_SITE;
          4'hE: v.tc = TC_V6_MC_PUBLIC;
          default: v.tc = TC_INVALID;
        endcase
      end else v.tc = TC_INVALID;
    end else if (lo == '0) v.tc = TC_ZERO;
    else if (lo == 64'd1) v.tc = TC_V6_LOCAL;
    else if (!mapped) v.tc = TC_INVALID;
    else if (o0 >= 8'd224) begin
      if (lo[31:0] == 32'hFFFF_FFFF) v.tc = TC_V4_BCAST;
      else if (o0 < 8'd239) v.tc = (lo[31:0] <= V4_MC_LINK_TOP) ? TC_V4_MC_LINK : TC_V4_MC_PUBLIC;
      else if (o0 == 8'd239) v.tc = TC_V4_MC_SITE;
      else v.tc = TC_INVALID;
    end else begin
      case (o0)
        8'd0:    v.tc = TC_INVALID;
        8'd10:   v.tc = TC_V4_SITE;
        8'd127:  v.tc = TC_V4_LOCAL;
        8'd169:  v.tc = (o1 == 8'd254) ? TC_V4_LINK : TC_V4_PUBLIC;
        8'd172:  v.tc = (o1[7:4] == 4'h1) ? TC_V4_SITE : TC_V4_PUBLIC;
        8'd192:  v.tc = (o1 == 8'd168) ? TC_V4_SITE : TC_V4_PUBLIC;
        default: v.tc = TC_V4_PUBLIC;
      endcase
    end

    // preference rank; unranked types get the none value
    case (v.tc)
      TC_V6_LOCAL:  v.sc = 8'd0;
      TC_V4_LOCAL:  v.sc = 8'd1;
      TC_V4_PUBLIC: v.sc = 8'd2;
      TC_V4_SITE:   v.sc = 8'd3;
      TC_V6_PUBLIC: v.sc = 8'd4;
      TC_V6_SITE:   v.sc = 8'd5;
      TC_V6_LINK:   v.sc = 8'd6;
      TC_V4_LINK:   v.sc = 8'd7;
      default:      v.sc = SCORE_NONE;
    endcase

    // public: note 0/8 is non-public even though broadcast etc. fall to o0 >= 224
    if (hi != '0) v.pub = (w0[15:13] == 3'b001);
    else if (!mapped) v.pub = 1'b0;
    else begin
      case (o0)
        8'd0, 8'd10, 8'd127: v.pub = 1'b0;
        8'd169:  v.pub = (o1 != 8'd254);
        8'd172:  v.pub = (o1[7:4] != 4'h1);
        8'd192:  v.pub = (o1 != 8'd168);
        default: v.pub = (o0 < 8'd224);
      endcase
    end

    // routable: three IPv4 windows on the top 16 bits, or 2000::/3 and fc00::/7
    if (hi != '0) v.rt = (w0[15:13] == 3'b001) || (w0[15:9] == 7'b1111_110);
    else v.rt = mapped && ((top16 >= 16'h0100 && top16 < 16'h7F00) ||
                           (top16 >= 16'h8000 && top16 < 16'hA9FE) ||
                           (top16 >= 16'hA9FF && top16 < 16'hE000));

    // subnet: IPv4 mask mode needs everything mapped and a nonzero mask
    if (mask_hi == '0)
      v.sn = (mask_lo[63:32] == V4_MAPPED_TAG) && mapped && ref_mapped &&
             (mask_lo[31:0] != '0) &&
             (((lo[31:0] ^ ref_lo[31:0]) & mask_lo[31:0]) == '0);
    else
      v.sn = !mapped && !ref_mapped && (((hi ^ ref_hi) & mask_hi) == '0) &&
             (((lo ^ ref_lo) & mask_lo) == '0);
    return v;
  endfunction

  // Random address, weighted toward the interesting parts of the space.
  function automatic request_t pick_address();
    request_t    r;
    logic [63:0] noise_hi;
    logic [63:0] noise_lo;
    logic [31:0] v4;
    logic [15:0] lead;
    int unsigned k;
    noise_hi = {$urandom, $urandom};
    noise_lo = {$urandom, $urandom};
    v4       = $urandom;
    r.hi     = '0;
    r.lo     = {V4_MAPPED_TAG, v4};
    case ($urandom_range(0, 9))
      0, 1: begin
        // IPv4 around the special first octets and second-octet ranges
        case ($urandom_range(0, 11))
          0: v4[31:24] = 8'd0;
          1: v4[31:24] = 8'd10;
          2: v4[31:24] = 8'd127;
          3: v4[31:24] = 8'd169;
          4: v4[31:24] = 8'd172;
          5: v4[31:24] = 8'd192;
          6: v4[31:24] = 8'd224;
          7: v4[31:24] = 8'd239;
          8: v4[31:24] = 8'd240;
          9: v4[31:24] = 8'd255;
          default: ;
        endcase
        case ($urandom_range(0, 3))
          0: v4[23:16] = 8'd254;
          1: v4[23:20] = 4'h1;
          2: v4[23:16] = 8'd168;
          default: ;
        endcase
        case ($urandom_range(0, 7))
          0: v4 = 32'hFFFF_FFFF;
          1: v4[31:8] = 24'hE0_0000;
          2: v4[31:8] = 24'hE0_0001;
          default: ;
        endcase
        r.lo = {V4_MAPPED_TAG, v4};
      end
      2: begin
        // edges of the routable windows
        case ($urandom_range(0, 11))
          0:  v4[31:16] = 16'h00FF;
          1:  v4[31:16] = 16'h0100;
          2:  v4[31:16] = 16'h7EFF;
          3:  v4[31:16] = 16'h7F00;
          4:  v4[31:16] = 16'h7FFF;
          5:  v4[31:16] = 16'h8000;
          6:  v4[31:16] = 16'hA9FD;
          7:  v4[31:16] = 16'hA9FE;
          8:  v4[31:16] = 16'hA9FF;
          9:  v4[31:16] = 16'hDFFF;
          10: v4[31:16] = 16'hE000;
          default: v4[31:16] = 16'hFFFF;
        endcase
        r.lo = {V4_MAPPED_TAG, v4};
      end
      3, 4: begin
        // inside the configured subnet, sometimes one bit off
        if (mask_hi == '0) begin
          r.lo = {V4_MAPPED_TAG, (ref_lo[31:0] & mask_lo[31:0]) | (noise_lo[31:0] & ~mask_lo[31:0])};
          if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 31);
            r.lo[k] = ~r.lo[k];
          end
        end else begin
          r.hi = (ref_hi & mask_hi) | (noise_hi & ~mask_hi);
          r.lo = (ref_lo & mask_lo) | (noise_lo & ~mask_lo);
          if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 127);
            if (k < 64) r.lo[k] = ~r.lo[k];
            else r.hi[k-64] = ~r.hi[k-64];
          end
        end
      end
      5, 6: begin
        // IPv6 with a leading word picked from the scope prefixes
        case ($urandom_range(0, 4))
          0: lead = {3'b001, 13'($urandom)};
          1: lead = {7'b1111_110, 9'($urandom)};
          2: lead = {10'b1111_1110_10, 6'($urandom)};
          3: lead = {8'hFF, 8'($urandom)};
          default: lead = 16'($urandom);
        endcase
        r.hi = {lead, noise_hi[47:0]};
        r.lo = noise_lo;
      end
      7: begin
        r.hi = noise_hi;
        r.lo = noise_lo;
      end
      8: begin
        // high half zero: zero, loopback, or a broken mapping tag
        case ($urandom_range(0, 3))
          0: r.lo = '0;
          1: r.lo = 64'd1;
          2: begin
            r.lo = {V4_MAPPED_TAG, v4};
            k = $urandom_range(32, 63);
            r.lo[k] = ~r.lo[k];
          end
          default: r.lo = noise_lo;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_raw(input logic [63:0] hi, input logic [63:0] lo);
    pending_q.push_back(request_t'({hi, lo}));
  endtask

  task automatic push_v4(input logic [31:0] a);
    pending_q.push_back(request_t'({64'h0, V4_MAPPED_TAG, a}));
  endtask

  // Config write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_REF_ADDR_HIGH: ref_hi  = value;
      REG_REF_ADDR_LOW:  ref_lo  = value;
      REG_MASK_HIGH:     mask_hi = value;
      REG_MASK_LOW:      mask_lo = value;
      default: ;
    endcase
  endtask

  // Sender stops; wait for every predicted result, then let the pipe settle.
  task automatic drain();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || predicted_scope_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [63:0] rh, input logic [63:0] rl,
                           input logic [63:0] mh, input logic [63:0] ml,
                           input bit with_gaps);
    paced = with_gaps;
    write_reg(REG_REF_ADDR_HIGH, rh);
    write_reg(REG_REF_ADDR_LOW, rl);
    write_reg(REG_MASK_HIGH, mh);
    write_reg(REG_MASK_LOW, ml);
    repeat (ITEMS_PER_PHASE) pending_q.push_back(pick_address());
    drain();
  endtask

  // Driver: predict on acceptance, then offer the next request after its gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predicted_scope_q.push_back(classify_address(addr_high, addr_low));
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          next_req  = pending_q.pop_front();
          addr_high <= next_req.hi;
          addr_low  <= next_req.lo;
          in_valid  <= 1'b1;
          send_wait = paced ? $urandom_range(0, 10) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, drive stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_scope_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = predicted_scope_q.pop_front();
          if (type_code !== want.tc) begin
            $error("type_code: expected %0d, got %0d", want.tc, type_code);
            errors++;
          end
          if (score !== want.sc) begin
            $error("score: expected %0d, got %0d", want.sc, score);
            errors++;
          end
          if (is_public !== want.pub) begin
            $error("is_public: expected %0b, got %0b", want.pub, is_public);
            errors++;
          end
          if (is_routable !== want.rt) begin
            $error("is_routable: expected %0b, got %0b", want.rt, is_routable);
            errors++;
          end
          if (same_subnet !== want.sn) begin
            $error("same_subnet: expected %0b, got %0b", want.sn, same_subnet);
            errors++;
          end
        end
        checked++;
        // long hold mid-run so both stages fill and in_stall rises
        if (checked == HOLD_AT) hold_left = HOLD_CYCLES;
        stall_left = paced ? $urandom_range(0, 10) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under reset config: every scope type and its edges.
    push_raw(64'h0, 64'h0);                          // all zero
    push_raw(64'h0, 64'h1);                          // ::1
    push_raw(64'h0, 64'h2);                          // high zero, not mapped
    push_raw(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);        // wrong mapping tag
    push_v4(32'h0001_0203);                          // 0/8
    push_v4(32'h0A01_0203);                          // 10/8
    push_v4(32'h7F00_0001);                          // loopback
    push_v4(32'hA9FE_0304);                          // 169.254/16
    push_v4(32'hAC1F_FFFF);                          // top of 172.16/12
    push_v4(32'hC0A8_0001);                          // 192.168/16
    push_v4(32'h0808_0808);                          // plain public
    push_v4(32'hE000_00FF);                          // last link-scope mcast
    push_v4(32'hE000_0100);                          // first public mcast
    push_v4(32'hEFFF_FFFF);                          // 239/8
    push_v4(32'hF000_0000);                          // reserved 240/4
    push_v4(32'hFFFF_FFFF);                          // limited broadcast
    push_raw(64'h2001_0DB8_0000_0000, 64'h1);        // global unicast
    push_raw(64'hFD00_0000_0000_0000, 64'h1);        // unique local
    push_raw(64'hFEBF_0000_0000_0000, 64'h0);        // top of fe80::/10
    push_raw(64'hFF02_0000_0000_0000, 64'h1);        // mcast link scope
    push_raw(64'hFF05_0000_0000_0000, 64'h0);        // mcast site scope
    push_raw(64'hFF0E_0000_0000_0000, 64'h0);        // mcast global scope
    push_raw(64'hFF01_0000_0000_0000, 64'h0);        // mcast, unknown scope
    push_raw(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_raw(64'h0001_0000_0000_0000, 64'h0);        // unassigned prefix
    drain();

    // IPv4 mask mode: /24, /32 with random ref, zero mask, unmapped mask/ref
    run_phase(64'h0, {V4_MAPPED_TAG, 32'hC0A8_0100}, 64'h0, {V4_MAPPED_TAG, 32'hFFFF_FF00}, 1'b1);
    run_phase(64'h0, {V4_MAPPED_TAG, 32'($urandom)}, 64'h0, {V4_MAPPED_TAG, 32'hFFFF_FFFF}, 1'b0);
    run_phase(64'h0, {V4_MAPPED_TAG, 32'h0A00_0000}, 64'h0, {V4_MAPPED_TAG, 32'h0}, 1'b1);
    run_phase(64'h0, {V4_MAPPED_TAG, 32'h0A00_0000}, 64'h0, {$urandom, $urandom}, 1'b1);
    run_phase(64'h0, {$urandom, $urandom}, 64'h0, {V4_MAPPED_TAG, 32'hFF00_0000}, 1'b0);
    // IPv6 mask mode: /32 prefix, full match, extremes, mapped reference
    run_phase(64'h2001_0DB8_0000_0000, 64'h0, 64'hFFFF_FFFF_0000_0000, 64'h0, 1'b1);
    run_phase(64'hFE80_0000_0000_0000, {$urandom, $urandom},
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    run_phase(64'h0, {V4_MAPPED_TAG, 32'hC0A8_0101},
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    run_phase({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
